[rtl/ris_pkg.sv]
// Package for the record insertion sorter: field widths, command and status codes,
// the insertion request type and the signed key comparison.
// No dependencies; every other file of the block refers to it by scoped names.
package ris_pkg;

    localparam int BYTE_W = 8;
    localparam int CMD_W  = 2;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 5;
    localparam int LEN_MAX = (1 << LEN_W) - 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_PARTIAL = 2'd3
    } t_status;

    // Insertion request broadcast along the chain of cells.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] key;
    } t_ins_req;

    // Two's-complement comparison a <= b.
    function automatic logic key_le(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
        return $signed(a) <= $signed(b);
    endfunction

endpackage

[rtl/ris_in_if.sv]
// Input channel of the record insertion sorter: valid, ready and one command item.
// Depends on ris_pkg for the field widths.
interface ris_in_if;
    logic                         valid;
    logic                         ready;
    logic [ris_pkg::CMD_W-1:0]    command;
    logic [ris_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

[rtl/ris_out_if.sv]
// Result channel of the record insertion sorter: valid, ready and one result item.
// Depends on ris_pkg for the field widths.
interface ris_out_if;
    logic                         valid;
    logic                         ready;
    logic [ris_pkg::BYTE_W-1:0]   out_byte;
    logic                         last_byte;
    logic [ris_pkg::ST_W-1:0]     status;

    modport source (output valid, output out_byte, output last_byte, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input last_byte, input status,
                    output ready);
endinterface

[rtl/ris_store.sv]
// Byte store of the record insertion sorter: one write port, one registered read port.
// Depends on ris_pkg for the byte width.
module ris_store #(
    parameter int DEPTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [ris_pkg::BYTE_W-1:0]        i_wdata,
    input  logic                              i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [ris_pkg::BYTE_W-1:0]        o_rdata
);

    logic [ris_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [ris_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ris_cell.sv]
// One cell of the sorted chain: holds one key and the index of its record.
// Depends on ris_pkg for the insertion request and the key comparison.
module ris_cell #(
    parameter int REC_W = 8
) (
    input  logic                        i_clk,
    input  ris_pkg::t_ins_req           i_ins,
    input  logic [REC_W-1:0]            i_new_rec,
    input  logic                        i_occ,
    input  logic                        i_left_keep,
    input  logic [ris_pkg::BYTE_W-1:0]  i_left_key,
    input  logic [REC_W-1:0]            i_left_rec,
    output logic                        o_keep,
    output logic [ris_pkg::BYTE_W-1:0]  o_key,
    output logic [REC_W-1:0]            o_rec
);

    logic [ris_pkg::BYTE_W-1:0] r_key;
    logic [REC_W-1:0]           r_rec;

    // A cell keeps its entry when it is occupied and its key does not exceed the new one.
    assign o_keep = i_occ && ris_pkg::key_le(r_key, i_ins.key);

    always_ff @(posedge i_clk) begin
        if (i_ins.valid && !o_keep) begin
            if (i_left_keep) begin
                r_key <= i_ins.key;
                r_rec <= i_new_rec;
            end else begin
                r_key <= i_left_key;
                r_rec <= i_left_rec;
            end
        end
    end

    assign o_key = r_key;
    assign o_rec = r_rec;

endmodule

[rtl/ris_chain.sv]
// Row of sorting cells that keeps record indices in key order, with rank selection.
// Depends on ris_pkg and ris_cell.
module ris_chain #(
    parameter int MAX_RECORDS = 256
) (
    input  logic                      i_clk,
    input  ris_pkg::t_ins_req         i_ins,
    input  logic [((MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1)-1:0] i_new_rec,
    input  logic [$clog2(MAX_RECORDS + 1)-1:0]                      i_records,
    input  logic [((MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1)-1:0] i_rank,
    output logic [((MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1)-1:0] o_rank_rec
);

    localparam int REC_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    logic                       w_keep [MAX_RECORDS];
    logic [ris_pkg::BYTE_W-1:0] w_key  [MAX_RECORDS];
    logic [REC_W-1:0]           w_rec  [MAX_RECORDS];

    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        logic                       w_occ;
        logic                       w_left_keep;
        logic [ris_pkg::BYTE_W-1:0] w_left_key;
        logic [REC_W-1:0]           w_left_rec;

        assign w_occ = CNT_W'(g) < i_records;

        if (g == 0) begin : g_head
            assign w_left_keep = 1'b1;
            assign w_left_key  = i_ins.key;
            assign w_left_rec  = i_new_rec;
        end else begin : g_body
            assign w_left_keep = w_keep[g-1];
            assign w_left_key  = w_key[g-1];
            assign w_left_rec  = w_rec[g-1];
        end

        ris_cell #(
            .REC_W (REC_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ins       (i_ins),
            .i_new_rec   (i_new_rec),
            .i_occ       (w_occ),
            .i_left_keep (w_left_keep),
            .i_left_key  (w_left_key),
            .i_left_rec  (w_left_rec),
            .o_keep      (w_keep[g]),
            .o_key       (w_key[g]),
            .o_rec       (w_rec[g])
        );
    end

    assign o_rank_rec = w_rec[i_rank];

endmodule

[rtl/record_insertion_sorter_core.sv]
// Record insertion sorter. Bytes arrive on the input channel as load commands and are
// grouped into records of a configurable length; each completed record is placed into a
// chain of cells, one cell per record, after every stored record whose signed first
// byte is less than or equal to its own, so equal keys keep arrival order. Every cell
// compares its key with the new one in the same cycle and shifts towards its
// neighbour, all cells together. Read commands return the bytes in
// sorted record order, flag the final byte, and first drop an incomplete trailing
// record with a partial-record status. A clear command or any write of the length
// register empties the set.
// The block takes one transfer per clock cycle unless the output is stalled; a result
// passes through the registered read port of the byte store, which moves with the first
// stage, and then the output register. Results follow back to back while the sink
// stays ready. No clearing pass is needed after reset.
module record_insertion_sorter_core #(
    parameter int MAX_RECORDS = 256,
    parameter int RECORD_MAX  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    ris_in_if.sink                    i_in,
    ris_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [ris_pkg::LEN_W-1:0] i_cfg_data
);

    localparam int REC_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int OFF_W  = (RECORD_MAX > 1) ? $clog2(RECORD_MAX) : 1;
    localparam int DEPTH  = MAX_RECORDS * RECORD_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LCW    = ((OFF_W > ris_pkg::LEN_W) ? OFF_W : ris_pkg::LEN_W) + 1;
    localparam int LEN_CAP_I = (RECORD_MAX < ris_pkg::LEN_MAX) ? RECORD_MAX : ris_pkg::LEN_MAX;
    localparam logic [ris_pkg::LEN_W-1:0] LEN_CAP = ris_pkg::LEN_W'(LEN_CAP_I);
    localparam logic [ADDR_W-1:0] REC_STRIDE = ADDR_W'(RECORD_MAX);

    typedef struct packed {
        logic             hit;
        logic             lb;
        ris_pkg::t_status st;
    } t_res;

    // Control state.
    logic [ris_pkg::LEN_W-1:0] r_len, n_len;
    logic [OFF_W-1:0]          r_off, n_off;
    logic [CNT_W-1:0]          r_records, n_records;
    logic [CNT_W-1:0]          r_rank, n_rank;
    logic [OFF_W-1:0]          r_boff, n_boff;
    logic                      r_s1_v;
    logic                      r_o_v;

    // Payload.
    logic [ris_pkg::BYTE_W-1:0] r_key, n_key;
    t_res                       r_s1;
    logic [ris_pkg::BYTE_W-1:0] r_o_byte;
    logic                       r_o_lb;
    ris_pkg::t_status           r_o_st;

    logic                       w_adv;
    logic                       w_in_ready;
    logic                       w_acc;
    ris_pkg::t_cmd              w_cmd;
    logic                       w_full;
    logic                       w_rank_hit;
    logic                       w_off_last;
    logic                       w_boff_last;
    logic                       w_rank_last;
    logic [ris_pkg::LEN_W-1:0]  w_cfg_len;
    t_res                       w_res;
    logic                       w_mem_we;
    logic                       w_mem_re;
    logic [ADDR_W-1:0]          w_waddr;
    logic [ADDR_W-1:0]          w_raddr;
    logic [ris_pkg::BYTE_W-1:0] w_mem_q;
    ris_pkg::t_ins_req          w_ins;
    logic [REC_W-1:0]           w_rank_rec;

    // Handshake: the first stage moves on whenever the output register is free or
    // being emptied, so a transfer is accepted while a finished result still waits.
    assign w_adv      = !r_o_v || o_out.ready;
    assign w_in_ready = !r_s1_v || w_adv;
    assign w_acc      = i_in.valid && w_in_ready;
    assign w_cmd      = ris_pkg::t_cmd'(i_in.command);

    assign w_full      = r_records == CNT_W'(MAX_RECORDS);
    assign w_rank_hit  = r_rank < r_records;
    assign w_off_last  = (LCW'(r_off) + LCW'(1)) == LCW'(r_len);
    assign w_boff_last = (LCW'(r_boff) + LCW'(1)) == LCW'(r_len);
    assign w_rank_last = (r_rank + CNT_W'(1)) == r_records;

    // A written length of zero counts as one; larger values saturate at the capacity.
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_len = ris_pkg::LEN_W'(1);
        end else if (i_cfg_data > LEN_CAP) begin
            w_cfg_len = LEN_CAP;
        end else begin
            w_cfg_len = i_cfg_data;
        end
    end

    // The record being filled always has the index equal to the record count, and the
    // key of a record is its first byte, taken straight from the input if the record
    // is one byte long.
    assign w_waddr = r_records[REC_W-1:0] * REC_STRIDE + ADDR_W'(r_off);
    assign w_raddr = w_rank_rec * REC_STRIDE + ADDR_W'(r_boff);

    always_comb begin
        n_len       = r_len;
        n_off       = r_off;
        n_key       = r_key;
        n_records   = r_records;
        n_rank      = r_rank;
        n_boff      = r_boff;
        w_res.hit   = 1'b0;
        w_res.lb    = 1'b0;
        w_res.st    = ris_pkg::ST_OK;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_ins.valid = 1'b0;
        w_ins.key   = (r_off == '0) ? i_in.data_byte : r_key;
        if (i_cfg_we) begin
            n_len     = w_cfg_len;
            n_off     = '0;
            n_records = '0;
            n_rank    = '0;
            n_boff    = '0;
        end else if (w_acc) begin
            unique case (w_cmd)
                ris_pkg::CMD_LOAD: begin
                    if (w_full) begin
                        w_res.st = ris_pkg::ST_FULL;
                    end else begin
                        w_mem_we = 1'b1;
                        if (r_off == '0) begin
                            n_key = i_in.data_byte;
                        end
                        if (w_off_last) begin
                            w_ins.valid = 1'b1;
                            n_off       = '0;
                            n_records   = r_records + CNT_W'(1);
                        end else begin
                            n_off = r_off + OFF_W'(1);
                        end
                    end
                end
                ris_pkg::CMD_READ: begin
                    // An incomplete trailing record is discarded before the read.
                    if (r_off != '0) begin
                        w_res.st = ris_pkg::ST_PARTIAL;
                        n_off    = '0;
                    end
                    if (w_rank_hit) begin
                        w_mem_re  = 1'b1;
                        w_res.hit = 1'b1;
                        w_res.lb  = w_rank_last && w_boff_last;
                        if (w_boff_last) begin
                            n_boff = '0;
                            n_rank = r_rank + CNT_W'(1);
                        end else begin
                            n_boff = r_boff + OFF_W'(1);
                        end
                    end else if (r_off == '0) begin
                        w_res.st = ris_pkg::ST_EMPTY;
                    end
                end
                ris_pkg::CMD_CLEAR: begin
                    n_off     = '0;
                    n_records = '0;
                    n_rank    = '0;
                    n_boff    = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= ris_pkg::LEN_W'(1);
            r_off     <= '0;
            r_records <= '0;
            r_rank    <= '0;
            r_boff    <= '0;
            r_s1_v    <= 1'b0;
            r_o_v     <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_off     <= n_off;
            r_records <= n_records;
            r_rank    <= n_rank;
            r_boff    <= n_boff;
            if (w_in_ready) begin
                r_s1_v <= w_acc;
            end
            if (w_adv) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    // The byte of a read arrives from the store together with the first stage, and the
    // output register picks it up when the stage moves on.
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (w_in_ready) begin
            r_s1 <= w_res;
        end
        if (w_adv) begin
            r_o_byte <= r_s1.hit ? w_mem_q : '0;
            r_o_lb   <= r_s1.lb;
            r_o_st   <= r_s1.st;
        end
    end

    ris_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.data_byte),
        .i_re    (w_mem_re),
        .i_raddr (w_raddr),
        .o_rdata (w_mem_q)
    );

    ris_chain #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ins      (w_ins),
        .i_new_rec  (r_records[REC_W-1:0]),
        .i_records  (r_records),
        .i_rank     (r_rank[REC_W-1:0]),
        .o_rank_rec (w_rank_rec)
    );

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = r_o_v;
    assign o_out.out_byte  = r_o_byte;
    assign o_out.last_byte = r_o_lb;
    assign o_out.status    = r_o_st;

`ifndef SYNTHESIS
    a_records_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_records <= CNT_W'(MAX_RECORDS))
        else $error("record count exceeds capacity");

    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rank <= r_records)
        else $error("read rank beyond stored records");

    a_off_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LCW'(r_off) < LCW'(r_len))
        else $error("fill offset not below record length");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_cfg_we && w_cmd == ris_pkg::CMD_LOAD && w_full)
        |=> (r_s1_v && r_s1.st == ris_pkg::ST_FULL))
        else $error("load into full store not flagged");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !w_adv) |=> (r_s1_v && $stable(r_s1)))
        else $error("stalled first stage lost its result");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for record_insertion_sorter_core: random and directed command
// streams with a scoreboard that sorts the records itself and checks every result.
// Depends on ris_pkg, ris_in_if, ris_out_if and the core itself.
`timescale 1ns / 1ps

module tb;

    localparam int NUM_RECORDS     = 256;
    localparam int RECORD_BYTES    = 16;
    localparam int ITEM_TARGET     = 1250;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 150;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;

    // The package names no code for the spare command value.
    localparam logic [ris_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [ris_pkg::BYTE_W-1:0] value;
        logic                       last;
        ris_pkg::t_status           code;
    } t_sorted_result;

    // Keeps its own copy of the record store and the sorted chain, and the queue
    // of results still to come from the block.
    class t_record_sort_tracker;
        logic [7:0]     record_bytes [NUM_RECORDS][RECORD_BYTES];
        int unsigned    sorted_index [NUM_RECORDS];
        byte            sorted_key [NUM_RECORDS];
        int unsigned    bytes_in;
        int unsigned    records_in;
        int unsigned    read_pos;
        int unsigned    rec_len;
        int unsigned    failures;
        t_sorted_result pending_results [$];

        function new();
            rec_len  = 1;
            failures = 0;
            empty_set();
        endfunction

        function void empty_set();
            bytes_in   = 0;
            records_in = 0;
            read_pos   = 0;
        endfunction

        function void set_length(input logic [ris_pkg::LEN_W-1:0] len);
            if (len == 0)
                rec_len = 1;
            else if (len > RECORD_BYTES)
                rec_len = RECORD_BYTES;
            else
                rec_len = len;
            empty_set();
        endfunction

        // Stable insertion: the new record goes after every key that is not greater.
        function void insert_record();
            byte         new_key;
            int unsigned pos;
            int unsigned i;
            new_key = byte'(record_bytes[records_in][0]);
            pos = 0;
            while (pos < records_in && sorted_key[pos] <= new_key)
                pos++;
            for (i = records_in; i > pos; i--) begin
                sorted_index[i] = sorted_index[i-1];
                sorted_key[i]   = sorted_key[i-1];
            end
            sorted_index[pos] = records_in;
            sorted_key[pos]   = new_key;
        endfunction

        function void note_command(input logic [ris_pkg::CMD_W-1:0] cmd,
                                   input logic [ris_pkg::BYTE_W-1:0] data);
            t_sorted_result res;
            int unsigned    fill;
            int unsigned    total;
            res  = '{value: 8'h00, last: 1'b0, code: ris_pkg::ST_OK};
            fill = bytes_in - records_in * rec_len;
            if (cmd == ris_pkg::CMD_LOAD) begin
                if (records_in >= NUM_RECORDS) begin
                    res.code = ris_pkg::ST_FULL;
                end else begin
                    record_bytes[records_in][fill] = data;
                    bytes_in++;
                    if (fill + 1 == rec_len) begin
                        insert_record();
                        records_in++;
                    end
                end
            end else if (cmd == ris_pkg::CMD_READ) begin
                // An unfinished record is thrown away before the read goes ahead.
                if (fill != 0) begin
                    bytes_in = records_in * rec_len;
                    res.code = ris_pkg::ST_PARTIAL;
                end
                total = records_in * rec_len;
                if (read_pos >= total) begin
                    if (res.code == ris_pkg::ST_OK)
                        res.code = ris_pkg::ST_EMPTY;
                end else begin
                    res.value = record_bytes[sorted_index[read_pos / rec_len]]
                                            [read_pos % rec_len];
                    read_pos++;
                    res.last = (read_pos == total);
                end
            end else if (cmd == ris_pkg::CMD_CLEAR) begin
                empty_set();
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(input logic [ris_pkg::BYTE_W-1:0] value,
                                   input logic last, input logic [ris_pkg::ST_W-1:0] code);
            t_sorted_result want;
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding: out_byte %0h last_byte %0b status %0d",
                       value, last, code);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (value !== want.value) begin
                $error("out_byte: expected %0h, actual %0h", want.value, value);
                failures++;
            end
            if (last !== want.last) begin
                $error("last_byte: expected %0b, actual %0b", want.last, last);
                failures++;
            end
            if (code !== want.code) begin
                $error("status: expected %0d, actual %0d", want.code, code);
                failures++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [ris_pkg::LEN_W-1:0]  cfg_data;

    ris_in_if  in_ch ();
    ris_out_if out_ch ();

    t_record_sort_tracker tracker = new();

    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned quiet_cycles = 0;
    bit          held_off     = 1'b0;

    record_insertion_sorter_core #(
        .MAX_RECORDS (NUM_RECORDS),
        .RECORD_MAX  (RECORD_BYTES)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Three stretches of traffic: slow receiver, then slow sender, then no gaps at all.
    function automatic int unsigned idle_phase();
        if (items_sent < ITEM_TARGET / 3)
            return 0;
        else if (items_sent < 2 * ITEM_TARGET / 3)
            return 1;
        return 2;
    endfunction

    function automatic bit sender_pause();
        case (idle_phase())
            0:       return $urandom_range(99) < 33;
            1:       return $urandom_range(99) < 77;
            default: return 1'b0;
        endcase
    endfunction

    // Keys lean towards the signed extremes and towards a few repeated values, so that
    // equal keys and the sign boundary come up often.
    function automatic logic [7:0] pick_key();
        case ($urandom_range(5))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'h40 + 8'($urandom_range(2));
            3:       return 8'hFF - 8'($urandom_range(1));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [ris_pkg::CMD_W-1:0] cmd,
                             input logic [ris_pkg::BYTE_W-1:0] data);
        @(negedge clk);
        while (sender_pause()) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.command   = cmd;
        in_ch.data_byte = data;
        do @(posedge clk); while (!in_ch.ready);
        tracker.note_command(cmd, data);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // The register is only written once every result is back and the pipeline has
    // had time to settle.
    task automatic configure(input logic [ris_pkg::LEN_W-1:0] len);
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (tracker.pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = len;
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.set_length(len);
    endtask

    task automatic load_records(input int unsigned count);
        int unsigned r;
        int unsigned b;
        for (r = 0; r < count; r++) begin
            send_item(ris_pkg::CMD_LOAD, pick_key());
            for (b = 1; b < tracker.rec_len; b++) begin
                // Now and then a stray command lands in the middle of a record.
                if ($urandom_range(39) == 0)
                    send_item(2'($urandom_range(3)), 8'($urandom));
                send_item(ris_pkg::CMD_LOAD, 8'($urandom));
            end
        end
    endtask

    task automatic read_bytes(input int unsigned count);
        repeat (count) send_item(ris_pkg::CMD_READ, 8'($urandom));
    endtask

    task automatic run_session();
        int unsigned count;
        int unsigned left;
        count = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
        if (tracker.rec_len >= 8 && count > 4)
            count = 4;
        load_records(count);
        if (tracker.rec_len > 1 && $urandom_range(3) == 0)
            repeat ($urandom_range(1, tracker.rec_len - 1))
                send_item(ris_pkg::CMD_LOAD, pick_key());
        left = tracker.records_in * tracker.rec_len - tracker.read_pos;
        if ($urandom_range(3) == 0) begin
            // Read part of the set, add more records, then read on to the end.
            read_bytes($urandom_range(1, left + 1));
            load_records($urandom_range(1, 3));
            left = tracker.records_in * tracker.rec_len - tracker.read_pos;
        end
        read_bytes(left + $urandom_range(2));
        if ($urandom_range(9) == 0)
            send_item(CMD_UNUSED, 8'($urandom));
        if ($urandom_range(1) == 0)
            send_item(ris_pkg::CMD_CLEAR, 8'($urandom));
    endtask

    // Receiver: random back-pressure, plus one long hold-off that fills the block up
    // while the sender keeps offering transfers.
    initial begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                held_off = 1'b1;
            end
            case (idle_phase())
                0:       out_ch.ready = $urandom_range(99) >= 77;
                1:       out_ch.ready = $urandom_range(99) >= 33;
                default: out_ch.ready = 1'b1;
            endcase
        end
    end

    // Result checking and the watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                tracker.check_result(out_ch.out_byte, out_ch.last_byte, out_ch.status);
                results_seen++;
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int unsigned plan_idx;
        logic [ris_pkg::LEN_W-1:0] len_plan [7];

        len_plan = '{5'd31, 5'd2, 5'd16, 5'd17, 5'd4, 5'd1, 5'd7};
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.command   = ris_pkg::CMD_LOAD;
        in_ch.data_byte = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset length of one byte: empty read, signed extremes,
        // the spare command, reading past the end and a clear.
        send_item(ris_pkg::CMD_READ, 8'h00);
        send_item(ris_pkg::CMD_LOAD, 8'h80);
        send_item(ris_pkg::CMD_LOAD, 8'h7F);
        send_item(ris_pkg::CMD_LOAD, 8'h00);
        send_item(ris_pkg::CMD_LOAD, 8'hFF);
        send_item(CMD_UNUSED, 8'hA5);
        read_bytes(5);
        send_item(ris_pkg::CMD_CLEAR, 8'h5A);
        send_item(ris_pkg::CMD_READ, 8'hFF);

        // Three-byte records: equal keys must keep arrival order, a negative key sorts
        // first, and a dangling byte is dropped by the next read.
        configure(5'd3);
        send_item(ris_pkg::CMD_LOAD, 8'h05);
        send_item(ris_pkg::CMD_LOAD, 8'h11);
        send_item(ris_pkg::CMD_LOAD, 8'h12);
        send_item(ris_pkg::CMD_LOAD, 8'h05);
        send_item(ris_pkg::CMD_LOAD, 8'h21);
        send_item(ris_pkg::CMD_LOAD, 8'h22);
        send_item(ris_pkg::CMD_LOAD, 8'h80);
        send_item(ris_pkg::CMD_LOAD, 8'h31);
        send_item(ris_pkg::CMD_LOAD, 8'h32);
        send_item(ris_pkg::CMD_LOAD, 8'h01);
        send_item(ris_pkg::CMD_READ, 8'h00);

        // Fill the store completely at a length of zero, which reads as one; the
        // long receiver hold-off falls in here.
        configure(5'd0);
        repeat (NUM_RECORDS + 2) send_item(ris_pkg::CMD_LOAD, pick_key());
        read_bytes(NUM_RECORDS + 1);

        plan_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            if (plan_idx < 7)
                configure(len_plan[plan_idx]);
            else
                configure(($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 4)));
            plan_idx++;
            repeat ($urandom_range(1, 3)) run_session();
        end

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[record_insertion_sorter_core.f]
rtl/ris_pkg.sv
rtl/ris_in_if.sv
rtl/ris_out_if.sv
rtl/ris_store.sv
rtl/ris_cell.sv
rtl/ris_chain.sv
rtl/record_insertion_sorter_core.sv
tb/tb.sv
